// ===== hdl/wsd_pkg.sv =====
// types and constants used by the websocket deframer core
package wsd_pkg;

  localparam int unsigned HdrCntW = 4;
  localparam int unsigned LenW    = 64;
  localparam int unsigned KeyW    = 32;

  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;

  localparam logic [HdrCntW-1:0] ExtBytes16 = 4'd2;
  localparam logic [HdrCntW-1:0] ExtBytes64 = 4'd8;
  localparam logic [HdrCntW-1:0] KeyBytes   = 4'd4;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_LEN  = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4,
    PH_DROP = 3'd5
  } wsd_phase_e;

  typedef enum logic [1:0] {
    ST_DATA   = 2'd0,
    ST_NOFIN  = 2'd1,
    ST_NOMASK = 2'd2,
    ST_EMPTY  = 2'd3
  } wsd_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } wsd_in_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        last_byte;
    wsd_status_e status;
  } wsd_out_t;

endpackage

// ===== hdl/wsd_stream_if.sv =====
// valid/ready stream interface carrying one payload beat
interface wsd_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/websocket_frame_deframer_core.sv =====
// websocket client frame deframer: header parse, unmask, result skid buffer
//
//  channel | dir | beat payload                          | handshake
//  in_i    | in  | data_byte, frame_start                | valid/ready
//  out_o   | out | payload_byte, last_byte, status       | valid/ready
//
// one input beat per cycle while ready is high; the header/payload state and the result
// are updated in the cycle the beat is taken; the result is registered in out_q, or in
// skid_q if out_o stalls; a two-entry output buffer (output register plus skid) keeps
// input ready while one result waits; ready drops only when both entries are full
// reset returns the parser to waiting for a first header byte, buffer empty
module websocket_frame_deframer_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  wsd_stream_if.sink   in_i,
  wsd_stream_if.source out_o
);
  import wsd_pkg::*;

  wsd_phase_e           phase_q, phase_d;
  logic [HdrCntW-1:0]   hdr_cnt_q, hdr_cnt_d;
  logic [LenW-1:0]      remain_q, remain_d;
  logic [KeyW-1:0]      key_q, key_d;
  logic [1:0]           key_idx_q, key_idx_d;

  wsd_in_t              beat;
  logic                 in_fire;
  logic                 res_valid;
  wsd_out_t             res;

  wsd_out_t             out_q, skid_q;
  logic                 out_vld_q, skid_vld_q;

  assign beat     = in_i.payload;
  assign in_i.ready = ~skid_vld_q;
  assign in_fire  = in_i.valid & ~skid_vld_q;

  always_comb begin
    logic [7:0] kb;
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    remain_d  = remain_q;
    key_d     = key_q;
    key_idx_d = key_idx_q;
    res_valid = 1'b0;
    res       = '{payload_byte: 8'd0, last_byte: 1'b0, status: ST_DATA};
    case (key_idx_q)
      2'd0:    kb = key_q[31:24];
      2'd1:    kb = key_q[23:16];
      2'd2:    kb = key_q[15:8];
      default: kb = key_q[7:0];
    endcase
    if (in_fire) begin
      if (beat.frame_start || (phase_q == PH_WAIT)) begin
        remain_d  = '0;
        key_d     = '0;
        key_idx_d = '0;
        hdr_cnt_d = '0;
        if (!beat.data_byte[7]) begin
          phase_d   = PH_DROP;
          res_valid = 1'b1;
          res       = '{payload_byte: 8'd0, last_byte: 1'b1, status: ST_NOFIN};
        end else begin
          phase_d = PH_LEN;
        end
      end else begin
        case (phase_q)
          PH_LEN: begin
            if (!beat.data_byte[7]) begin
              phase_d   = PH_DROP;
              res_valid = 1'b1;
              res       = '{payload_byte: 8'd0, last_byte: 1'b1, status: ST_NOMASK};
            end else begin
              remain_d = '0;
              if (beat.data_byte[6:0] == Len7Ext16) begin
                hdr_cnt_d = ExtBytes16;
                phase_d   = PH_EXT;
              end else if (beat.data_byte[6:0] == Len7Ext64) begin
                hdr_cnt_d = ExtBytes64;
                phase_d   = PH_EXT;
              end else begin
                remain_d  = {{(LenW-7){1'b0}}, beat.data_byte[6:0]};
                hdr_cnt_d = KeyBytes;
                phase_d   = PH_KEY;
              end
            end
          end
          PH_EXT: begin
            // big-endian extended length shifts in from the bottom
            remain_d  = {remain_q[LenW-9:0], beat.data_byte};
            hdr_cnt_d = hdr_cnt_q - 1'b1;
            if (hdr_cnt_q == 4'd1) begin
              hdr_cnt_d = KeyBytes;
              phase_d   = PH_KEY;
            end
          end
          PH_KEY: begin
            key_d     = {key_q[KeyW-9:0], beat.data_byte};
            hdr_cnt_d = hdr_cnt_q - 1'b1;
            if (hdr_cnt_q == 4'd1) begin
              key_idx_d = '0;
              if (remain_q == '0) begin
                phase_d   = PH_WAIT;
                res_valid = 1'b1;
                res       = '{payload_byte: 8'd0, last_byte: 1'b1, status: ST_EMPTY};
              end else begin
                phase_d = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            key_idx_d = key_idx_q + 2'd1;
            remain_d  = remain_q - 1'b1;
            res_valid = 1'b1;
            res.payload_byte = beat.data_byte ^ kb;
            if (remain_q == {{(LenW-1){1'b0}}, 1'b1}) begin
              phase_d       = PH_WAIT;
              res.last_byte = 1'b1;
            end
          end
          default: begin
            phase_d = PH_DROP;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      hdr_cnt_q <= '0;
      remain_q  <= '0;
      key_q     <= '0;
      key_idx_q <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      remain_q  <= remain_d;
      key_q     <= key_d;
      key_idx_q <= key_idx_d;
    end
  end

  // output register with a skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || out_o.ready) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_o.ready) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

endmodule
